// ===== rtl/mbvq_pkg.sv =====
// ----------------------------------------------------------------------------
// mbvq_pkg
// Shared types, widths, codes and decision functions of the MBVQ halftoner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbvq_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LW_W       = 11;
    localparam int WCMP_W     = ((COL_W > LW_W) ? COL_W : LW_W) + 1;
    localparam int THR_W      = 8;
    localparam int PIX_W      = 8;
    localparam int FRAC_BITS  = 4;
    localparam int WSUM_SHIFT = 4;
    localparam int CV_W       = 10 + FRAC_BITS;
    localparam int SUM_W      = CV_W + 2;
    localparam int ERR_W      = CV_W + 4;
    localparam int ACC_W      = ERR_W + 2;
    localparam int XW         = ACC_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int RIDX_W     = 1;
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = OQ_PTR_W + 1;
    localparam int S_DATA_W   = 3 * PIX_W;
    localparam int M_DATA_W   = 8;

    localparam logic [RIDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [RIDX_W-1:0] REG_THRESHOLD  = 1'd1;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = LW_W'(640);
    localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(128);

    // quadrant codes
    localparam logic [2:0] Q_KRGB = 3'd0;
    localparam logic [2:0] Q_CMYW = 3'd1;
    localparam logic [2:0] Q_MYGC = 3'd2;
    localparam logic [2:0] Q_RGMY = 3'd3;
    localparam logic [2:0] Q_RGBM = 3'd4;
    localparam logic [2:0] Q_CMGB = 3'd5;

    // vertex codes, bit 2 red, bit 1 green, bit 0 blue
    localparam logic [2:0] VX_K = 3'd0;
    localparam logic [2:0] VX_B = 3'd1;
    localparam logic [2:0] VX_G = 3'd2;
    localparam logic [2:0] VX_C = 3'd3;
    localparam logic [2:0] VX_R = 3'd4;
    localparam logic [2:0] VX_M = 3'd5;
    localparam logic [2:0] VX_Y = 3'd6;
    localparam logic [2:0] VX_W = 3'd7;

    localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(255 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SUM_TWO  = SUM_W'(510 << FRAC_BITS);
    localparam logic signed [XW-1:0]    CORR_MIN = -XW'(256 << FRAC_BITS);
    localparam logic signed [XW-1:0]    CORR_MAX = XW'((512 << FRAC_BITS) - 1);
    localparam logic signed [ERR_W-1:0] FULL_ON  = ERR_W'(255 << FRAC_BITS);
    localparam logic signed [ERR_W-1:0] WGT_1    = ERR_W'(1);
    localparam logic signed [ERR_W-1:0] WGT_3    = ERR_W'(3);
    localparam logic signed [ERR_W-1:0] WGT_5    = ERR_W'(5);
    localparam logic signed [ERR_W-1:0] WGT_7    = ERR_W'(7);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (WSUM_SHIFT - 1));

    typedef logic [2:0][ERR_W-1:0] err_word_t;
    typedef logic [2:0][PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        err_word_t        data;
    } mem_wr_t;

    typedef struct packed {
        pix_t             pix;
        logic             sof;
        logic             first;
        logic             last;
        logic             has_behind;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] behind;
    } scan_item_t;

    typedef struct packed {
        logic [2:0] quad;
        logic       blue_on;
        logic       green_on;
        logic       red_on;
    } result_t;

    function automatic logic [2:0] pick_quadrant(
        input logic signed [CV_W-1:0] r,
        input logic signed [CV_W-1:0] g,
        input logic signed [CV_W-1:0] b
    );
        logic signed [SUM_W-1:0] rg;
        logic signed [SUM_W-1:0] gb;
        logic signed [SUM_W-1:0] rgb;
        logic [2:0]              q;
        rg  = SUM_W'(r) + SUM_W'(g);
        gb  = SUM_W'(g) + SUM_W'(b);
        rgb = rg + SUM_W'(b);
        if (rg > SUM_ONE) begin
            if (gb > SUM_ONE) begin
                q = (rgb > SUM_TWO) ? Q_CMYW : Q_MYGC;
            end else begin
                q = Q_RGMY;
            end
        end else if (gb <= SUM_ONE) begin
            q = (rgb <= SUM_ONE) ? Q_KRGB : Q_RGBM;
        end else begin
            q = Q_CMGB;
        end
        return q;
    endfunction

    function automatic logic [2:0] pick_vertex(
        input logic [2:0]             q,
        input logic signed [CV_W-1:0] rv,
        input logic signed [CV_W-1:0] gv,
        input logic signed [CV_W-1:0] bv,
        input logic [THR_W-1:0]       thr
    );
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] t;
        logic [2:0]              vx;
        r  = SUM_W'(rv);
        g  = SUM_W'(gv);
        b  = SUM_W'(bv);
        t  = $signed({{(SUM_W - THR_W - FRAC_BITS){1'b0}}, thr, {FRAC_BITS{1'b0}}});
        vx = VX_K;
        case (q)
            Q_CMYW: begin
                if (b < t && b < r && b <= g)       vx = VX_Y;
                else if (g < t && g <= b && g <= r) vx = VX_M;
                else if (r < t && r <= b && r <= g) vx = VX_C;
                else                                vx = VX_W;
            end
            Q_MYGC: begin
                if (g >= b && r >= b)      vx = (r >= t) ? VX_Y : VX_G;
                else if (g >= r && b >= r) vx = (b >= t) ? VX_C : VX_G;
                else                       vx = VX_M;
            end
            Q_RGMY: begin
                if (b > t) begin
                    if (r > t) vx = (b >= g) ? VX_M : VX_Y;
                    else       vx = (g > b + r) ? VX_G : VX_M;
                end else if (r >= t) begin
                    vx = (g >= t) ? VX_Y : VX_R;
                end else begin
                    vx = (r >= g) ? VX_R : VX_G;
                end
            end
            Q_KRGB: begin
                if (b > t && b >= r && b >= g)      vx = VX_B;
                else if (g > t && g >= b && g >= r) vx = VX_G;
                else if (r > t && r >= b && r >= g) vx = VX_R;
                else                                vx = VX_K;
            end
            Q_RGBM: begin
                if (r > g && r >= b)      vx = (b < t) ? VX_R : VX_M;
                else if (b > g && b >= r) vx = (r < t) ? VX_B : VX_M;
                else                      vx = VX_G;
            end
            default: begin
                if (b > t) begin
                    if (r > t) vx = (g >= r) ? VX_C : VX_M;
                    else       vx = (g > t) ? VX_C : VX_B;
                end else if (r > t) begin
                    vx = (r - g + b >= t) ? VX_M : VX_G;
                end else begin
                    vx = (g >= b) ? VX_G : VX_B;
                end
            end
        endcase
        return vx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbvq_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbvq_scan_ctrl
// Serpentine scan position, line memory read address and pixel stage register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbvq_scan_ctrl import mbvq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  pix_t             pix,
    input  logic             sof,
    input  logic [LW_W-1:0]  line_width,
    output logic [COL_W-1:0] rd_addr,
    output logic             item_valid,
    output scan_item_t       item
);

    logic [COL_W-1:0]  col_cnt_reg;
    logic [COL_W-1:0]  col_cnt_next;
    logic              odd_reg;
    logic              odd_next;
    logic              first_reg;
    logic              first_next;
    logic              item_valid_reg;
    scan_item_t        item_reg;

    logic [COL_W-1:0]  cnt0;
    logic              odd0;
    logic              first0;
    logic [WCMP_W-1:0] w_eff;
    logic [COL_W-1:0]  w_last;
    logic [COL_W-1:0]  cnt_e;
    logic [COL_W-1:0]  col;
    logic              last;

    always_comb begin
        cnt0   = sof ? '0 : col_cnt_reg;
        odd0   = sof ? 1'b0 : odd_reg;
        first0 = sof ? 1'b1 : first_reg;
        if (line_width == '0) begin
            w_eff = WCMP_W'(1);
        end else if (WCMP_W'(line_width) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = WCMP_W'(line_width);
        end
        w_last = COL_W'(w_eff - WCMP_W'(1));
        cnt_e  = (WCMP_W'(cnt0) >= w_eff) ? w_last : cnt0;
        col    = odd0 ? (w_last - cnt_e) : cnt_e;
        last   = (cnt_e == w_last);
        if (last) begin
            col_cnt_next = '0;
            odd_next     = !odd0;
            first_next   = 1'b0;
        end else begin
            col_cnt_next = cnt_e + COL_W'(1);
            odd_next     = odd0;
            first_next   = first0;
        end
    end

    assign rd_addr    = col;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg    <= '0;
            odd_reg        <= 1'b0;
            first_reg      <= 1'b1;
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= accept;
            if (accept) begin
                col_cnt_reg <= col_cnt_next;
                odd_reg     <= odd_next;
                first_reg   <= first_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.pix        <= pix;
            item_reg.sof        <= sof;
            item_reg.first      <= first0;
            item_reg.last       <= last;
            item_reg.has_behind <= (cnt_e != '0);
            item_reg.col        <= col;
            item_reg.behind     <= odd0 ? (col + COL_W'(1)) : (col - COL_W'(1));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbvq_err_mem.sv =====
// ----------------------------------------------------------------------------
// mbvq_err_mem
// Next-row error line memory with forwarding of the two most recent writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbvq_err_mem import mbvq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  mem_wr_t          beh_wr,
    input  mem_wr_t          pend_wr,
    input  logic [COL_W-1:0] fwd_addr,
    output err_word_t        rd_data
);

    err_word_t mem [MAX_WIDTH];
    err_word_t rd_reg;
    mem_wr_t   wr_port;
    mem_wr_t   last_wr_reg;

    // end-of-row write never coincides with a behind write
    assign wr_port = pend_wr.en ? pend_wr : beh_wr;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_port.en) begin
            mem[wr_port.addr] <= wr_port.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_wr_reg.en <= 1'b0;
        end else begin
            last_wr_reg <= wr_port;
        end
    end

    always_comb begin
        if (pend_wr.en && pend_wr.addr == fwd_addr) begin
            rd_data = pend_wr.data;
        end else if (last_wr_reg.en && last_wr_reg.addr == fwd_addr) begin
            rd_data = last_wr_reg.data;
        end else begin
            rd_data = rd_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbvq_quantizer.sv =====
// ----------------------------------------------------------------------------
// mbvq_quantizer
// Error correction, MBVQ quadrant and vertex choice, Floyd-Steinberg spread.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbvq_quantizer import mbvq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  scan_item_t       item,
    input  err_word_t        row_err,
    input  logic [THR_W-1:0] threshold,
    output result_t          result,
    output mem_wr_t          beh_wr,
    output mem_wr_t          pend_wr
);

    err_word_t ahead_reg;
    err_word_t ahead_next;
    err_word_t near_reg;
    err_word_t near_next;
    err_word_t far_reg;
    err_word_t far_next;
    mem_wr_t   pend_reg;
    mem_wr_t   pend_next;

    logic signed [ERR_W-1:0] ahead_c [3];
    logic signed [ERR_W-1:0] near_c  [3];
    logic signed [ERR_W-1:0] far_c   [3];
    logic signed [ERR_W-1:0] mem_c   [3];
    logic signed [ACC_W-1:0] acc     [3];
    logic signed [ACC_W-1:0] rnd     [3];
    logic signed [XW-1:0]    x       [3];
    logic signed [CV_W-1:0]  v       [3];
    logic signed [ERR_W-1:0] es      [3];
    logic signed [ERR_W-1:0] far_new [3];
    logic [2:0]              quad;
    logic [2:0]              vert;
    err_word_t               beh_data;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ahead_c[c] = item.sof ? '0 : $signed(ahead_reg[c]);
            near_c[c]  = item.sof ? '0 : $signed(near_reg[c]);
            far_c[c]   = item.sof ? '0 : $signed(far_reg[c]);
            mem_c[c]   = item.first ? '0 : $signed(row_err[c]);
            acc[c]     = ACC_W'(ahead_c[c]) + ACC_W'(mem_c[c]);
            rnd[c]     = (acc[c] + RND_HALF) >>> WSUM_SHIFT;
            x[c]       = $signed({{(XW - PIX_W - FRAC_BITS){1'b0}}, item.pix[c],
                                  {FRAC_BITS{1'b0}}}) + XW'(rnd[c]);
            if (x[c] < CORR_MIN) begin
                v[c] = CV_W'(CORR_MIN);
            end else if (x[c] > CORR_MAX) begin
                v[c] = CV_W'(CORR_MAX);
            end else begin
                v[c] = CV_W'(x[c]);
            end
        end

        quad = pick_quadrant(v[0], v[1], v[2]);
        vert = pick_vertex(quad, v[0], v[1], v[2], threshold);

        for (int c = 0; c < 3; c++) begin
            es[c]       = ERR_W'(v[c]) - (vert[2 - c] ? FULL_ON : '0);
            far_new[c]  = near_c[c] + es[c] * WGT_5;
            beh_data[c] = far_c[c] + es[c] * WGT_3;
            if (item.last) begin
                ahead_next[c] = '0;
                near_next[c]  = '0;
                far_next[c]   = '0;
            end else begin
                ahead_next[c] = es[c] * WGT_7;
                near_next[c]  = es[c] * WGT_1;
                far_next[c]   = far_new[c];
            end
            pend_next.data[c] = far_new[c];
        end
        pend_next.en   = item_valid && item.last;
        pend_next.addr = item.col;
    end

    assign beh_wr.en       = item_valid && item.has_behind;
    assign beh_wr.addr     = item.behind;
    assign beh_wr.data     = beh_data;
    assign pend_wr         = pend_reg;
    assign result.quad     = quad;
    assign result.red_on   = vert[2];
    assign result.green_on = vert[1];
    assign result.blue_on  = vert[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ahead_reg   <= '0;
            near_reg    <= '0;
            far_reg     <= '0;
            pend_reg.en <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (item_valid) begin
                ahead_reg <= ahead_next;
                near_reg  <= near_next;
                far_reg   <= far_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbvq_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mbvq_out_fifo
// Small result queue that decouples the error loop from output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbvq_out_fifo import mbvq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  result_t             push_data,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_data,
    output logic [OQ_CNT_W-1:0] count
);

    result_t               q_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg;
    logic [OQ_CNT_W-1:0]   cnt_reg;
    logic [OQ_CNT_W-1:0]   cnt_next;
    logic                  pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign count     = cnt_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + OQ_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbvq_error_diffusion_halftone.sv =====
// ----------------------------------------------------------------------------
// mbvq_error_diffusion_halftone
// MBVQ colour error-diffusion halftoner on a serpentine scan, top level.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock and returns one on/off bit per channel plus the
// MBVQ quadrant, in input order. A pixel accepted at one edge has its line
// memory entry read at that edge, is quantized in the next cycle, and its result
// is pushed into the result queue, whose count drives m_tvalid. Throughput is
// one pixel per clock while the queue has room, set by the forward error loop
// in the quantizer, updated combinationally from its row registers, and the
// one read port and one write port of the next-row error memory; only output
// back-pressure slows intake, through a four-entry result queue. Rows run left
// to right on even rows and right to left on odd rows; s_tuser marks the first
// pixel of a frame. The error memory needs no clearing after reset: the first
// row of each frame ignores it. Registers: line_width at 0x0, vertex_threshold
// at 0x4, to be written only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mbvq_error_diffusion_halftone import mbvq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // start_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // red_on, green_on, blue_on, quadrant
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LW_W-1:0]     line_width_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [RIDX_W-1:0]   reg_idx;
    logic                cfg_wr;

    logic                accept;
    logic [COL_W-1:0]    rd_addr;
    logic                item_valid;
    scan_item_t          item;
    err_word_t           row_err;
    mem_wr_t             beh_wr;
    mem_wr_t             pend_wr;
    result_t             result;
    result_t             out_data;
    logic [OQ_CNT_W-1:0] oq_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LINE_WIDTH: line_width_reg <= pwdata[LW_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_WIDTH: prdata = APB_DATA_W'(line_width_reg);
            REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    // room for everything in flight, no transfer during reset
    assign s_tready = aresetn &&
                      (((OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(item_valid))
                       < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign accept   = s_tvalid && s_tready;

    mbvq_scan_ctrl u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .pix        (s_tdata),
        .sof        (s_tuser),
        .line_width (line_width_reg),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item)
    );

    mbvq_err_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .beh_wr   (beh_wr),
        .pend_wr  (pend_wr),
        .fwd_addr (item.col),
        .rd_data  (row_err)
    );

    mbvq_quantizer u_quant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .row_err    (row_err),
        .threshold  (threshold_reg),
        .result     (result),
        .beh_wr     (beh_wr),
        .pend_wr    (pend_wr)
    );

    mbvq_out_fifo u_oq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_valid),
        .push_data (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .count     (oq_count)
    );

    assign m_tdata = M_DATA_W'(out_data);

endmodule

`default_nettype wire

// ===== rtl/mbvq_checker.sv =====
// ----------------------------------------------------------------------------
// mbvq_checker
// Port-level checks of the halftoner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbvq_checker import mbvq_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result two cycles after a transfer");

    a_krgb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:3] == Q_KRGB |-> $countones(m_tdata[2:0]) <= 1)
        else $error("KRGB quadrant gave a vertex outside it");

    a_cmyw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:3] == Q_CMYW |-> $countones(m_tdata[2:0]) >= 2)
        else $error("CMYW quadrant gave a vertex outside it");

endmodule

bind mbvq_error_diffusion_halftone mbvq_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/tb_mbvq_error_diffusion_halftone.sv =====
// ----------------------------------------------------------------------------
// tb_mbvq_error_diffusion_halftone
// Self-checking bench for the MBVQ serpentine error-diffusion halftoner.
// ----------------------------------------------------------------------------
// A queue of pixels feeds a stream driver. Each accepted pixel runs through a
// bench-side predictor that keeps its own error line, row registers and
// register copies, and the expected dot is queued. Every result transfer is
// compared field by field with the oldest expectation. The run starts with
// two short directed frames, then runs random phases at several line widths
// (including zero and beyond the maximum), thresholds at both extremes and
// different idling mixes on both sides. Widths only shrink within a frame.
`timescale 1ns / 1ps

module tb_mbvq_error_diffusion_halftone;
    import mbvq_pkg::*;

    localparam int                    WATCHDOG_LIMIT = 5000;
    localparam int                    TAIL_CYCLES    = 8;
    localparam int                    N_PHASES       = 9;
    localparam int                    N_DIRECTED     = 20;
    localparam logic [APB_ADDR_W-1:0] LW_ADDR        = {REG_LINE_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] THR_ADDR       = {REG_THRESHOLD, 2'b00};
    localparam int                    LVL_ONE        = 255 << FRAC_BITS;
    localparam int                    LVL_TWO        = 510 << FRAC_BITS;
    localparam int                    CORR_LO        = -(256 << FRAC_BITS);
    localparam int                    CORR_HI        = (512 << FRAC_BITS) - 1;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             sof;
    } pixel_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;    // red_in, green_in, blue_in
    logic                  s_tuser  = 1'b0;  // start_of_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_DATA_W-1:0]   m_tdata;          // red_on, green_on, blue_on, quadrant
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pixel_t  pixel_q[$];
    result_t dot_q[$];
    logic    s_took = 1'b0;
    int      src_gap_pct = 0;
    int      sink_stall_pct = 0;
    int      n_fail = 0;
    int      quiet_cycles = 0;

    // predictor state
    int      err_row[MAX_WIDTH][3];
    int      ahead_err[3] = '{0, 0, 0};
    int      near_err[3] = '{0, 0, 0};
    int      far_err[3] = '{0, 0, 0};
    int      col_cnt = 0;
    bit      odd_row_q = 1'b0;
    bit      first_row_q = 1'b1;
    int      cfg_width = int'(LINE_WIDTH_RST);
    int      cfg_thr = int'(THRESHOLD_RST);

    mbvq_error_diffusion_halftone u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int eff_width(input int w);
        if (w == 0) begin
            return 1;
        end
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function automatic result_t halftone_pixel(input pixel_t px);
        int         w, col, e, acc, x, r, g, b, t, ch;
        int         v[3];
        logic [7:0] chan[3];
        logic [2:0] q, vx;
        result_t    res;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        if (px.sof) begin
            col_cnt     = 0;
            odd_row_q   = 1'b0;
            first_row_q = 1'b1;
            ahead_err   = '{0, 0, 0};
            near_err    = '{0, 0, 0};
            far_err     = '{0, 0, 0};
        end
        w = eff_width(cfg_width);
        if (col_cnt >= w) begin
            col_cnt = w - 1;
        end
        col = odd_row_q ? (w - 1 - col_cnt) : col_cnt;
        for (ch = 0; ch < 3; ch++) begin
            acc = ahead_err[ch] + (first_row_q ? 0 : err_row[col][ch]);
            // weights are sixteenths, round half up
            x = (int'(chan[ch]) << FRAC_BITS) + ((acc + 8) >>> 4);
            if (x < CORR_LO) x = CORR_LO;
            if (x > CORR_HI) x = CORR_HI;
            v[ch] = x;
        end
        r = v[0];
        g = v[1];
        b = v[2];
        t = cfg_thr << FRAC_BITS;

        if (r + g > LVL_ONE) begin
            if (g + b > LVL_ONE) begin
                q = (r + g + b > LVL_TWO) ? Q_CMYW : Q_MYGC;
            end else begin
                q = Q_RGMY;
            end
        end else if (g + b <= LVL_ONE) begin
            q = (r + g + b <= LVL_ONE) ? Q_KRGB : Q_RGBM;
        end else begin
            q = Q_CMGB;
        end

        case (q)
            Q_CMYW: begin
                if (b < t && b < r && b <= g)       vx = VX_Y;
                else if (g < t && g <= b && g <= r) vx = VX_M;
                else if (r < t && r <= b && r <= g) vx = VX_C;
                else                                vx = VX_W;
            end
            Q_MYGC: begin
                if (g >= b && r >= b)      vx = (r >= t) ? VX_Y : VX_G;
                else if (g >= r && b >= r) vx = (b >= t) ? VX_C : VX_G;
                else                       vx = VX_M;
            end
            Q_RGMY: begin
                if (b > t) begin
                    if (r > t) vx = (b >= g) ? VX_M : VX_Y;
                    else       vx = (g > b + r) ? VX_G : VX_M;
                end else if (r >= t) begin
                    vx = (g >= t) ? VX_Y : VX_R;
                end else begin
                    vx = (r >= g) ? VX_R : VX_G;
                end
            end
            Q_KRGB: begin
                if (b > t && b >= r && b >= g)      vx = VX_B;
                else if (g > t && g >= b && g >= r) vx = VX_G;
                else if (r > t && r >= b && r >= g) vx = VX_R;
                else                                vx = VX_K;
            end
            Q_RGBM: begin
                if (r > g && r >= b)      vx = (b < t) ? VX_R : VX_M;
                else if (b > g && b >= r) vx = (r < t) ? VX_B : VX_M;
                else                      vx = VX_G;
            end
            default: begin
                if (b > t) begin
                    if (r > t) vx = (g >= r) ? VX_C : VX_M;
                    else       vx = (g > t) ? VX_C : VX_B;
                end else if (r > t) begin
                    vx = (r - g + b >= t) ? VX_M : VX_G;
                end else begin
                    vx = (g >= b) ? VX_G : VX_B;
                end
            end
        endcase

        for (ch = 0; ch < 3; ch++) begin
            e = v[ch] - (vx[2 - ch] ? LVL_ONE : 0);
            if (col_cnt > 0) begin
                err_row[odd_row_q ? col + 1 : col - 1][ch] = far_err[ch] + 3 * e;
            end
            far_err[ch]   = near_err[ch] + 5 * e;
            near_err[ch]  = e;
            ahead_err[ch] = 7 * e;
        end

        if (col_cnt >= w - 1) begin
            for (ch = 0; ch < 3; ch++) begin
                err_row[col][ch] = far_err[ch];
            end
            ahead_err   = '{0, 0, 0};
            near_err    = '{0, 0, 0};
            far_err     = '{0, 0, 0};
            col_cnt     = 0;
            odd_row_q   = !odd_row_q;
            first_row_q = 1'b0;
        end else begin
            col_cnt++;
        end

        res.red_on   = vx[2];
        res.green_on = vx[1];
        res.blue_on  = vx[0];
        res.quad     = q;
        return res;
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(118, 138));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input int data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(data);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid || dot_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // stream driver
    always @(negedge aclk) begin : drive
        pixel_t nxt;
        if (aresetn) begin
            if (!s_tvalid || s_took) begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    nxt = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.blue, nxt.green, nxt.red};
                    s_tuser  <= nxt.sof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin : observe
        result_t want, got;
        pixel_t  px;
        s_took <= s_tvalid && s_tready;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    LW_ADDR:  cfg_width = int'(pwdata[LW_W-1:0]);
                    THR_ADDR: cfg_thr = int'(pwdata[THR_W-1:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (dot_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                             $time, m_tdata);
                    n_fail++;
                end else begin
                    want = dot_q.pop_front();
                    report_field("red_on", want.red_on, got.red_on);
                    report_field("green_on", want.green_on, got.green_on);
                    report_field("blue_on", want.blue_on, got.blue_on);
                    report_field("quadrant", want.quad, got.quad);
                end
            end
            if (s_tvalid && s_tready) begin
                px.red   = s_tdata[PIX_W-1:0];
                px.green = s_tdata[2*PIX_W-1:PIX_W];
                px.blue  = s_tdata[3*PIX_W-1:2*PIX_W];
                px.sof   = s_tuser;
                dot_q.push_back(halftone_pixel(px));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int          dir_rgb[N_DIRECTED] = '{
            'h000000, 'hffffff, 'hff0000, 'h00ff00, 'h0000ff, 'hffff00, 'hff00ff,
            'h00ffff, 'h808080, 'h7f7f7f, 'h40c020, 'hc81edc, 'h0afa82, 'h81807f,
            'hffffff, 'h000000, 'h01fe80, 'h5a5a5a, 'haaaaaa, 'h55aaff};
        // width 0 and 2047 probe the clamps; the 1030-pixel phase ends in an odd row
        // that the next, narrower phase cuts short
        int          ph_width[N_PHASES] = '{0, 5, 7, 2047, 6, 16, 3, 11, 1};
        int          ph_thr[N_PHASES]   = '{255, 0, 200, 128, 100, 60, 128, 255, 0};
        int          ph_count[N_PHASES] = '{60, 150, 150, 1030, 100, 150, 100, 120, 90};
        int          ph_src[N_PHASES]   = '{0, 69, 0, 33, 0, 69, 0, 33, 0};
        int          ph_sink[N_PHASES]  = '{0, 0, 69, 33, 0, 0, 69, 33, 0};
        int          prev_eff, cur_eff, p, k;
        pixel_t      px;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_write(LW_ADDR, 3);
        apb_write(THR_ADDR, 128);
        for (k = 0; k < N_DIRECTED; k++) begin
            px.red   = 8'(dir_rgb[k] >> 16);
            px.green = 8'(dir_rgb[k] >> 8);
            px.blue  = 8'(dir_rgb[k]);
            px.sof   = (k == 0 || k == 14);
            pixel_q.push_back(px);
        end
        drain();
        prev_eff = 3;

        for (p = 0; p < N_PHASES; p++) begin
            apb_write(LW_ADDR, ph_width[p]);
            apb_write(THR_ADDR, ph_thr[p]);
            src_gap_pct    = ph_src[p];
            sink_stall_pct = ph_sink[p];
            cur_eff        = eff_width(ph_width[p]);
            for (k = 0; k < ph_count[p]; k++) begin
                if (p == 1 && k == ph_count[p] / 2) begin
                    // sender holds off until the pipe is empty
                    drain();
                end
                px.red   = rand_level();
                px.green = rand_level();
                px.blue  = rand_level();
                // a wider row needs a new frame so the error line is never read unwritten
                px.sof   = (k == 0 && cur_eff > prev_eff) ||
                           (cur_eff <= 16 && $urandom_range(0, 49) == 0);
                pixel_q.push_back(px);
            end
            drain();
            prev_eff = cur_eff;
        end

        if (n_fail == 0 && dot_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
